[sv/hcpl_pkg.sv]
// Shared types, command and status codes, and constants of the hex camera pixel locator.
package hcpl_pkg;

  typedef enum logic [1:0] {
    CMD_LOCATE = 2'd0,
    CMD_MAP_WR = 2'd1,
    CMD_CTR_WR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_LOCATED     = 2'd0,
    ST_OUTSIDE_PIX = 2'd1,
    ST_OUTSIDE_MAP = 2'd2,
    ST_WRITE_DONE  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_PIXEL_WIDTH  = 2'd0,
    CFG_CORNER_WIDTH = 2'd1,
    CFG_CELL_RECIP   = 2'd2
  } cfg_e;

  localparam logic signed [17:0] SIN60_Q16 = 18'sd56756;
  localparam logic [18:0]        SLOPE_Q20 = 19'd443180;
  localparam logic [31:0]        EMPTY_WORD = 32'h7FF0_0000;

  localparam logic [15:0] PW_RST = 16'd7680;
  localparam logic [16:0] CW_RST = 17'd15360;
  localparam logic [23:0] RC_RST = 24'd37283;

  localparam int T_W  = 39;
  localparam int PP_W = 52;
  localparam int D_W  = 64;
  localparam int K_W  = 17;
  localparam int KC_W = 19;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic [6:0]         map_i;
    logic [6:0]         map_j;
    logic               shared;
    logic signed [10:0] id_a;
    logic [9:0]         id_b;
    logic [9:0]         id_c;
    logic [9:0]         pix;
  } item_t;

  typedef struct packed {
    logic [6:0]            hex_i;
    logic [6:0]            hex_j;
    logic signed [KC_W-1:0] ki;
    logic signed [KC_W-1:0] kj;
  } loc_t;

endpackage

[sv/hcpl_coord.sv]
// Seven-stage pipeline from a point to its corrected rounded hexagonal cube coordinates.
module hcpl_coord import hcpl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic [23:0] recip_i,
  input  logic        v_i,
  input  item_t       item_i,
  output logic        v_o,
  output item_t       item_o,
  output loc_t        loc_o
);

  localparam int NS = 7;

  logic [NS-1:0]          v_q;
  item_t                  it_q [NS];
  logic signed [37:0]     p_q, p_d;
  logic signed [T_W-1:0]  t_q [3];
  logic signed [T_W-1:0]  t_d [3];
  logic signed [PP_W-1:0] lo_q [3];
  logic signed [PP_W-1:0] lo_d [3];
  logic signed [PP_W-1:0] hi_q [3];
  logic signed [PP_W-1:0] hi_d [3];
  logic signed [D_W-1:0]  d_q [3];
  logic signed [D_W-1:0]  d_d [3];
  logic [62:0]            mag_q [3];
  logic [62:0]            mag_d [3];
  logic [2:0]             neg_q, neg_d;
  logic signed [K_W-1:0]  k_q [3];
  logic signed [K_W-1:0]  k_d [3];
  logic [47:0]            err_q [3];
  logic [47:0]            err_d [3];
  loc_t                   loc_q, loc_d;

  always_comb begin
    logic signed [T_W-1:0]  ys;
    logic signed [T_W-1:0]  yk;
    logic signed [T_W-1:0]  pe;
    logic signed [D_W-1:0]  negd;
    logic [47:0]            frac;
    logic [15:0]            kmag;
    logic signed [K_W-1:0]  kpos;
    logic signed [KC_W-1:0] ki, kj, kk, s;
    p_d  = SIN60_Q16 * item_i.x;
    ys   = {{4{it_q[0].y[19]}}, it_q[0].y, 15'd0};
    yk   = {{3{it_q[0].y[19]}}, it_q[0].y, 16'd0};
    pe   = {p_q[37], p_q};
    t_d[0] = pe + ys;
    t_d[1] = ys - pe;
    t_d[2] = T_W'(0) - yk;
    for (int n = 0; n < 3; n++) begin
      lo_d[n] = t_q[n] * $signed({1'b0, recip_i[11:0]});
      hi_d[n] = t_q[n] * $signed({1'b0, recip_i[23:12]});
      d_d[n]  = {{(D_W-PP_W){lo_q[n][PP_W-1]}}, lo_q[n]} + {hi_q[n], 12'd0};
      negd     = D_W'(0) - d_q[n];
      neg_d[n] = d_q[n][D_W-1];
      mag_d[n] = d_q[n][D_W-1] ? negd[62:0] : d_q[n][62:0];
      frac      = mag_q[n][47:0];
      kmag      = {1'b0, mag_q[n][62:48]} + 16'(frac[47]);
      kpos      = {1'b0, kmag};
      k_d[n]    = neg_q[n] ? K_W'(0) - kpos : kpos;
      err_d[n]  = frac[47] ? 48'd0 - frac : frac;
    end
    ki = {{(KC_W-K_W){k_q[0][K_W-1]}}, k_q[0]};
    kj = {{(KC_W-K_W){k_q[1][K_W-1]}}, k_q[1]};
    kk = {{(KC_W-K_W){k_q[2][K_W-1]}}, k_q[2]};
    s  = ki + kj + kk;
    if (s != '0) begin
      if (err_q[0] >= err_q[1] && err_q[0] >= err_q[2]) begin
        ki = ki - s;
      end else if (err_q[1] >= err_q[0] && err_q[1] >= err_q[2]) begin
        kj = kj - s;
      end
    end
    loc_d.ki    = ki;
    loc_d.kj    = kj;
    loc_d.hex_i = ki[6:0];
    loc_d.hex_j = kj[6:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[NS-2:0], v_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      it_q[0] <= item_i;
      for (int n = 1; n < NS; n++) begin
        it_q[n] <= it_q[n-1];
      end
      p_q   <= p_d;
      neg_q <= neg_d;
      for (int n = 0; n < 3; n++) begin
        t_q[n]   <= t_d[n];
        lo_q[n]  <= lo_d[n];
        hi_q[n]  <= hi_d[n];
        d_q[n]   <= d_d[n];
        mag_q[n] <= mag_d[n];
        k_q[n]   <= k_d[n];
        err_q[n] <= err_d[n];
      end
      loc_q <= loc_d;
    end
  end

  assign v_o    = v_q[NS-1];
  assign item_o = it_q[NS-1];
  assign loc_o  = loc_q;

endmodule

[sv/hcpl_cell.sv]
// Cell map memory with its clearing pass, map writes and the registered map read.
module hcpl_cell import hcpl_pkg::*; #(
  parameter int MAP_SIDE = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        v_i,
  input  item_t       item_i,
  input  loc_t        loc_i,
  output logic        busy_o,
  output logic        v_o,
  output item_t       item_o,
  output loc_t        loc_o,
  output logic        outside_o,
  output logic [31:0] word_o
);

  localparam int DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int HALF  = MAP_SIDE / 2;

  logic [31:0]     mem [DEPTH];
  logic            busy_q;
  logic [AW-1:0]   cnt_q;
  logic            a_v_q, b_v_q;
  item_t           a_item_q, b_item_q;
  loc_t            a_loc_q, b_loc_q;
  logic            a_out_q, b_out_q, a_out_d;
  logic            a_wr_q, a_wr_d;
  logic [AW-1:0]   a_addr_q, a_addr_d;
  logic [31:0]     a_word_q, a_word_d, rdata_q;

  always_comb begin
    logic signed [KC_W:0] ri, rj;
    logic                 inr;
    logic [AW-1:0]        raddr, waddr;
    ri    = $signed({loc_i.ki[KC_W-1], loc_i.ki}) + (KC_W+1)'(HALF);
    rj    = $signed({loc_i.kj[KC_W-1], loc_i.kj}) + (KC_W+1)'(HALF);
    inr   = ri >= 0 && ri < (KC_W+1)'(MAP_SIDE) && rj >= 0 && rj < (KC_W+1)'(MAP_SIDE);
    raddr = AW'(ri) * AW'(MAP_SIDE) + AW'(rj);
    waddr = AW'(item_i.map_i) * AW'(MAP_SIDE) + AW'(item_i.map_j);
    a_out_d  = item_i.cmd == CMD_LOCATE && !inr;
    a_wr_d   = item_i.cmd == CMD_MAP_WR && 32'(item_i.map_i) < MAP_SIDE
               && 32'(item_i.map_j) < MAP_SIDE;
    a_addr_d = item_i.cmd == CMD_MAP_WR ? waddr : raddr;
    a_word_d = {item_i.shared, item_i.id_a, item_i.id_b, item_i.id_c};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      a_v_q  <= 1'b0;
      b_v_q  <= 1'b0;
    end else begin
      if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == AW'(DEPTH - 1)) begin
          busy_q <= 1'b0;
        end
      end
      if (adv_i) begin
        a_v_q <= v_i;
        b_v_q <= a_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_item_q <= item_i;
      a_loc_q  <= loc_i;
      a_out_q  <= a_out_d;
      a_wr_q   <= a_wr_d;
      a_addr_q <= a_addr_d;
      a_word_q <= a_word_d;
      b_item_q <= a_item_q;
      b_loc_q  <= a_loc_q;
      b_out_q  <= a_out_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[cnt_q] <= EMPTY_WORD;
    end else if (adv_i && a_v_q && a_wr_q) begin
      mem[a_addr_q] <= a_word_q;
    end
    if (adv_i) begin
      rdata_q <= mem[a_addr_q];
    end
  end

  assign busy_o    = busy_q;
  assign v_o       = b_v_q;
  assign item_o    = b_item_q;
  assign loc_o     = b_loc_q;
  assign outside_o = b_out_q;
  assign word_o    = rdata_q;

endmodule

[sv/hcpl_match.sv]
// Pixel centre memories, big-hexagon tests of the candidates and the result register.
module hcpl_match import hcpl_pkg::*; #(
  parameter int MAX_PIXELS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic [15:0]        pw_i,
  input  logic [16:0]        cw_i,
  input  logic               v_i,
  input  item_t              item_i,
  input  loc_t               loc_i,
  input  logic               outside_i,
  input  logic [31:0]        word_i,
  output logic               v_o,
  output logic signed [10:0] found_o,
  output logic [1:0]         status_o,
  output logic [6:0]         hex_i_o,
  output logic [6:0]         hex_j_o
);

  localparam int PAW = $clog2(MAX_PIXELS);

  typedef struct packed {
    logic signed [10:0] found;
    logic [1:0]         status;
    logic [6:0]         hex_i;
    logic [6:0]         hex_j;
    logic               test;
    logic [2:0]         ok;
    logic [29:0]        cand;
    logic signed [19:0] x;
    logic signed [19:0] y;
  } res_t;

  logic [2:0]   v_q;
  res_t         r_q [3];
  res_t         r_d;
  logic [39:0]  crd_q [3];
  logic [10:0]  cand [3];
  logic [20:0]  dx_q [3];
  logic [20:0]  dx_d [3];
  logic [20:0]  dy_q [3];
  logic [20:0]  dy_d [3];
  logic [20:0]  dy3_q [3];
  logic [39:0]  prod_q [3];
  logic [39:0]  prod_d [3];
  logic [2:0]   dxok_q, dxok_d;
  logic         wr_en;
  logic         out_v_q;
  logic signed [10:0] found_q, found_d;
  logic [1:0]   status_q, status_d;
  logic [6:0]   hi_q, hj_q;

  assign cand[0] = word_i[30:20];
  assign cand[1] = {1'b0, word_i[19:10]};
  assign cand[2] = {1'b0, word_i[9:0]};
  assign wr_en   = adv_i && v_i && item_i.cmd == CMD_CTR_WR
                   && 32'(item_i.pix) < MAX_PIXELS;

  always_comb begin
    r_d        = '0;
    r_d.x      = item_i.x;
    r_d.y      = item_i.y;
    r_d.cand   = {word_i[9:0], word_i[19:10], word_i[29:20]};
    r_d.found  = 11'sd0;
    r_d.status = ST_WRITE_DONE;
    for (int n = 0; n < 3; n++) begin
      r_d.ok[n] = $signed(cand[n]) > 11'sd0 && int'($signed(cand[n])) < MAX_PIXELS;
    end
    if (item_i.cmd == CMD_LOCATE) begin
      r_d.hex_i = loc_i.hex_i;
      r_d.hex_j = loc_i.hex_j;
      if (outside_i) begin
        r_d.found  = -11'sd1;
        r_d.status = ST_OUTSIDE_MAP;
      end else if (word_i[31]) begin
        r_d.test   = 1'b1;
        r_d.found  = -11'sd1;
        r_d.status = ST_OUTSIDE_PIX;
      end else if (word_i[30]) begin
        r_d.found  = -11'sd1;
        r_d.status = ST_OUTSIDE_PIX;
      end else begin
        r_d.found  = $signed(word_i[30:20]);
        r_d.status = ST_LOCATED;
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_ctr
    logic [39:0] cmem [MAX_PIXELS];
    always_ff @(posedge clk_i) begin
      if (wr_en) begin
        cmem[item_i.pix[PAW-1:0]] <= {item_i.y, item_i.x};
      end
      if (adv_i) begin
        crd_q[g] <= cmem[cand[g][PAW-1:0]];
      end
    end
  end

  always_comb begin
    logic signed [20:0] ddx, ddy;
    logic signed [41:0] rhs, lhs;
    logic               hit;
    found_d  = r_q[2].found;
    status_d = r_q[2].status;
    hit      = 1'b0;
    for (int n = 0; n < 3; n++) begin
      ddx = {r_q[0].x[19], r_q[0].x} - {crd_q[n][19], crd_q[n][19:0]};
      ddy = {r_q[0].y[19], r_q[0].y} - {crd_q[n][39], crd_q[n][39:20]};
      dx_d[n]   = ddx[20] ? 21'd0 - ddx : ddx;
      dy_d[n]   = ddy[20] ? 21'd0 - ddy : ddy;
      prod_d[n] = SLOPE_Q20 * dx_q[n];
      dxok_d[n] = dx_q[n] <= 21'(pw_i);
      rhs = $signed({5'd0, cw_i, 20'd0}) - $signed({2'd0, prod_q[n]});
      lhs = $signed({1'd0, dy3_q[n], 20'd0});
      if (!hit && r_q[2].test && r_q[2].ok[n] && dxok_q[n] && lhs <= rhs) begin
        hit      = 1'b1;
        found_d  = $signed({1'b0, r_q[2].cand[n*10 +: 10]});
        status_d = ST_LOCATED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else if (adv_i) begin
      v_q     <= {v_q[1:0], v_i};
      out_v_q <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      r_q[0] <= r_d;
      r_q[1] <= r_q[0];
      r_q[2] <= r_q[1];
      dxok_q <= dxok_d;
      for (int n = 0; n < 3; n++) begin
        dx_q[n]   <= dx_d[n];
        dy_q[n]   <= dy_d[n];
        dy3_q[n]  <= dy_q[n];
        prod_q[n] <= prod_d[n];
      end
      found_q  <= found_d;
      status_q <= status_d;
      hi_q     <= r_q[2].hex_i;
      hj_q     <= r_q[2].hex_j;
    end
  end

  assign v_o      = out_v_q;
  assign found_o  = found_q;
  assign status_o = status_q;
  assign hex_i_o  = hi_q;
  assign hex_j_o  = hj_q;

endmodule

[sv/hex_camera_pixel_locator.sv]
// Top level of the hex camera pixel locator: configuration, pipeline control and assertions.
//
//   channel  | handshake              | payload
//   input    | in_valid_i / in_stall_o | cmd_i x_i y_i map_i_i map_j_i entry_* pixel_index_i
//   output   | out_valid_o / out_stall_i | found_pixel_o status_o hex_i_o hex_j_o
//   config   | cfg_we_i               | cfg_idx_i cfg_data_i
//
// A new transaction can enter every cycle while in_stall_o is low.
// Map reads and writes share one port of the cell map; centres live in three copies.
// After reset all MAP_SIDE*MAP_SIDE cell map entries are cleared while in_stall_o is held high.
// A stall at the output freezes the whole pipeline, and in_stall_o follows it.
module hex_camera_pixel_locator import hcpl_pkg::*; #(
  parameter int MAP_SIDE   = 128,
  parameter int MAX_PIXELS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [19:0] x_i,
  input  logic signed [19:0] y_i,
  input  logic [6:0]         map_i_i,
  input  logic [6:0]         map_j_i,
  input  logic               entry_shared_i,
  input  logic signed [10:0] entry_id_a_i,
  input  logic [9:0]         entry_id_b_i,
  input  logic [9:0]         entry_id_c_i,
  input  logic [9:0]         pixel_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [10:0] found_pixel_o,
  output logic [1:0]         status_o,
  output logic signed [6:0]  hex_i_o,
  output logic signed [6:0]  hex_j_o
);

  logic [15:0] pw_q;
  logic [16:0] cw_q;
  logic [23:0] rc_q;
  logic        adv, busy;
  item_t       item_in, c_item, m_item;
  loc_t        c_loc, m_loc;
  logic        c_v, m_v, m_out;
  logic [31:0] m_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q <= PW_RST;
      cw_q <= CW_RST;
      rc_q <= RC_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PIXEL_WIDTH:  pw_q <= cfg_data_i[15:0];
        CFG_CORNER_WIDTH: cw_q <= cfg_data_i[16:0];
        CFG_CELL_RECIP:   rc_q <= cfg_data_i;
        default:          pw_q <= pw_q;
      endcase
    end
  end

  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = busy || !adv;

  assign item_in = '{cmd: cmd_i, x: x_i, y: y_i, map_i: map_i_i, map_j: map_j_i,
                     shared: entry_shared_i, id_a: entry_id_a_i, id_b: entry_id_b_i,
                     id_c: entry_id_c_i, pix: pixel_index_i};

  hcpl_coord u_coord (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .recip_i (rc_q),
    .v_i     (in_valid_i && !busy),
    .item_i  (item_in),
    .v_o     (c_v),
    .item_o  (c_item),
    .loc_o   (c_loc)
  );

  hcpl_cell #(.MAP_SIDE(MAP_SIDE)) u_cell (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .v_i       (c_v),
    .item_i    (c_item),
    .loc_i     (c_loc),
    .busy_o    (busy),
    .v_o       (m_v),
    .item_o    (m_item),
    .loc_o     (m_loc),
    .outside_o (m_out),
    .word_o    (m_word)
  );

  hcpl_match #(.MAX_PIXELS(MAX_PIXELS)) u_match (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .pw_i      (pw_q),
    .cw_i      (cw_q),
    .v_i       (m_v),
    .item_i    (m_item),
    .loc_i     (m_loc),
    .outside_i (m_out),
    .word_i    (m_word),
    .v_o       (out_valid_o),
    .found_o   (found_pixel_o),
    .status_o  (status_o),
    .hex_i_o   (hex_i_o),
    .hex_j_o   (hex_j_o)
  );

  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> in_stall_o) else $error("input taken during map clear");

  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_WRITE_DONE |->
      found_pixel_o == 11'sd0 && hex_i_o == 7'sd0 && hex_j_o == 7'sd0)
    else $error("write transaction with nonzero result");

  a_map_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_OUTSIDE_MAP || status_o == ST_OUTSIDE_PIX) |->
      found_pixel_o == -11'sd1) else $error("miss without pixel -1");

  a_located: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_LOCATED |-> !found_pixel_o[10])
    else $error("located with negative pixel");

endmodule
